FILE: design/dbsd_pkg.sv
// ---------------------------------------------------------------------------
// dbsd_pkg
// Shared constants and types for the dead-block SRRIP/BIP replacement core.
// ---------------------------------------------------------------------------
package dbsd_pkg;

    localparam int DEF_SETS         = 2048;
    localparam int DEF_WAYS         = 16;
    localparam int DEF_LEADER_SETS  = 64;
    localparam int DEF_DECAY_PERIOD = 8192;

    localparam int SET_W  = 11;
    localparam int WAY_W  = 4;
    localparam int MASK_W = 16;
    localparam int DRAW_W = 5;
    localparam int SEL_W  = 10;

    localparam logic [SEL_W-1:0] SEL_RESET = 10'd512;
    localparam logic [SEL_W-1:0] SEL_MAX   = 10'd1023;

    localparam logic [1:0] RRPV_DISTANT = 2'd3;
    localparam logic [1:0] RRPV_LONG    = 2'd2;

    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Item as classified by the front end
    typedef struct packed {
        logic              cmd;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way;
        logic              hit;
        logic [MASK_W-1:0] valid_mask;
        logic [DRAW_W-1:0] bip_draw;
        logic              lead_srrip;
        logic              lead_bip;
        logic              has_invalid;
        logic [WAY_W-1:0]  first_invalid;
    } dbsd_item_t;

endpackage

FILE: design/dbsd_front.sv
// ---------------------------------------------------------------------------
// dbsd_front
// Accepts items, wraps indices, flags leader sets and finds the first
// invalid way, then places them in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module dbsd_front
    import dbsd_pkg::*;
#(
    parameter int SETS        = DEF_SETS,
    parameter int WAYS        = DEF_WAYS,
    parameter int LEADER_SETS = DEF_LEADER_SETS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              cmd,
    input  logic [SET_W-1:0]  set_index,
    input  logic [WAY_W-1:0]  way,
    input  logic              hit,
    input  logic [MASK_W-1:0] valid_mask,
    input  logic [DRAW_W-1:0] bip_draw,
    output logic              q_valid,
    output dbsd_item_t        q_item,
    input  logic              q_take
);

    localparam int SI_W = $clog2(SETS);
    localparam int WI_W = $clog2(WAYS);

    dbsd_item_t item;
    logic [SI_W-1:0] set_w;
    logic [WI_W-1:0] way_w;
    logic [31:0] set_ext;

    always_comb
    begin
        logic found;
        found = 1'b0;
        item = '0;
        set_w = SI_W'(set_index);
        way_w = WI_W'(way);
        set_ext = 32'(set_w);
        item.cmd = cmd;
        item.set_index = SET_W'(set_w);
        item.way = WAY_W'(way_w);
        item.hit = hit;
        item.valid_mask = valid_mask;
        item.bip_draw = bip_draw;
        item.lead_srrip = set_ext < 32'(LEADER_SETS);
        item.lead_bip = set_ext >= 32'(SETS / 2) && set_ext < 32'(SETS / 2 + LEADER_SETS);
        // ways beyond the mask count as valid
        for (int w = 0; w < WAYS && w < MASK_W; w++)
        begin
            if (!found && !valid_mask[w])
            begin
                found = 1'b1;
                item.first_invalid = WAY_W'(w);
            end
        end
        item.has_invalid = found;
    end

    dbsd_item_t buf_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic       wr_en;

    assign full   = cnt_reg == 2'd2;
    assign wr_en  = push && !full;
    assign q_valid = cnt_reg != 2'd0;
    assign q_item = buf_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_reg[wr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_reg <= !wr_reg;
            end
            if (q_take)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(q_take);
        end
    end

endmodule

FILE: design/dbsd_back.sv
// ---------------------------------------------------------------------------
// dbsd_back
// Metadata store, selector and fill counter. Reads one set row, modifies it
// and writes it back; runs the clearing and decay sweeps over the rows.
// ---------------------------------------------------------------------------
module dbsd_back
    import dbsd_pkg::*;
#(
    parameter int SETS         = DEF_SETS,
    parameter int WAYS         = DEF_WAYS,
    parameter int DECAY_PERIOD = DEF_DECAY_PERIOD
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  dbsd_item_t       q_item,
    output logic             q_take,
    output logic             empty,
    input  logic             pop,
    output logic [WAY_W-1:0] victim_way,
    output logic [SEL_W-1:0] selector_value
);

    localparam int SI_W  = $clog2(SETS);
    localparam int ROW_W = 4 * WAYS;
    localparam int FC_W  = $clog2(DECAY_PERIOD + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_DRD   = 3'd4;
    localparam logic [2:0] ST_DWR   = 3'd5;

    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] rdata_reg;
    logic [SI_W-1:0]  raddr;
    logic             re;
    logic [SI_W-1:0]  waddr;
    logic [ROW_W-1:0] wdata;
    logic             we;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    logic [2:0]       state_reg, state_next;
    logic [SI_W-1:0]  ptr_reg, ptr_next;
    logic [SEL_W-1:0] sel_reg, sel_next;
    logic [FC_W-1:0]  fc_reg, fc_next;
    dbsd_item_t       cur_reg, cur_next;
    logic             ov_reg, ov_next;
    logic [WAY_W-1:0] ovw_reg, ovw_next;
    logic [SEL_W-1:0] ovs_reg, ovs_next;

    assign empty = !ov_reg;
    assign victim_way = ovw_reg;
    assign selector_value = ovs_reg;

    logic [WAY_W-1:0] vic;
    logic [ROW_W-1:0] row_new;
    logic [ROW_W-1:0] row_decay;
    logic [SEL_W-1:0] sel_upd;
    logic             start_decay;

    always_comb
    begin
        logic [1:0] maxr, add, ru, ins, bip;
        logic       fnd;
        logic [$clog2(WAYS)-1:0] wi;
        maxr = 2'd0;
        fnd = 1'b0;
        ins = RRPV_DISTANT;
        vic = '0;
        row_new = rdata_reg;
        sel_upd = sel_reg;
        start_decay = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rdata_reg[4*w +: 2] > maxr)
            begin
                maxr = rdata_reg[4*w +: 2];
            end
        end
        add = RRPV_DISTANT - maxr;
        bip = (cur_reg.bip_draw == '0) ? RRPV_LONG : RRPV_DISTANT;
        wi = $bits(wi)'(cur_reg.way);
        ru = rdata_reg[4*wi + 2 +: 2];
        if (cur_reg.cmd == CMD_VICTIM)
        begin
            if (cur_reg.has_invalid)
            begin
                vic = cur_reg.first_invalid;
            end
            else
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    row_new[4*w +: 2] = rdata_reg[4*w +: 2] + add;
                    if (!fnd && rdata_reg[4*w +: 2] == maxr)
                    begin
                        fnd = 1'b1;
                        vic = WAY_W'(w);
                    end
                end
            end
        end
        else if (cur_reg.hit)
        begin
            row_new[4*wi +: 2] = 2'd0;
            row_new[4*wi + 2 +: 2] = (ru == 2'd3) ? 2'd3 : ru + 2'd1;
            if (cur_reg.lead_srrip && sel_upd != SEL_MAX)
            begin
                sel_upd = sel_upd + 1'b1;
            end
            if (cur_reg.lead_bip && sel_upd != '0)
            begin
                sel_upd = sel_upd - 1'b1;
            end
        end
        else
        begin
            if (ru == 2'd0)
            begin
                ins = RRPV_DISTANT;
            end
            else if (cur_reg.lead_srrip)
            begin
                ins = RRPV_LONG;
            end
            else if (cur_reg.lead_bip)
            begin
                ins = bip;
            end
            else
            begin
                ins = (sel_reg >= SEL_RESET) ? RRPV_LONG : bip;
            end
            row_new[4*wi +: 2] = ins;
            row_new[4*wi + 2 +: 2] = 2'd0;
            start_decay = (fc_reg + 1'b1) >= FC_W'(DECAY_PERIOD);
        end
        row_decay = rdata_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rdata_reg[4*w + 2 +: 2] != 2'd0)
            begin
                row_decay[4*w + 2 +: 2] = rdata_reg[4*w + 2 +: 2] - 2'd1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        sel_next = sel_reg;
        fc_next = fc_reg;
        cur_next = cur_reg;
        ov_next = ov_reg && !pop;
        ovw_next = ovw_reg;
        ovs_next = ovs_reg;
        q_take = 1'b0;
        re = 1'b0;
        raddr = cur_reg.set_index[SI_W-1:0];
        we = 1'b0;
        waddr = cur_reg.set_index[SI_W-1:0];
        wdata = row_new;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                waddr = ptr_reg;
                wdata = '0;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == SI_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && !ov_next)
                begin
                    q_take = 1'b1;
                    cur_next = q_item;
                    re = 1'b1;
                    raddr = q_item.set_index[SI_W-1:0];
                    state_next = ST_EXEC;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                we = 1'b1;
                sel_next = sel_upd;
                ov_next = 1'b1;
                ovw_next = vic;
                ovs_next = sel_upd;
                state_next = ST_IDLE;
                if (cur_reg.cmd == CMD_UPDATE && !cur_reg.hit)
                begin
                    fc_next = fc_reg + 1'b1;
                    if (start_decay)
                    begin
                        fc_next = '0;
                        ptr_next = '0;
                        state_next = ST_DRD;
                    end
                end
            end
            ST_DRD:
            begin
                re = 1'b1;
                raddr = ptr_reg;
                state_next = ST_DWR;
            end
            ST_DWR:
            begin
                we = 1'b1;
                waddr = ptr_reg;
                wdata = row_decay;
                ptr_next = ptr_reg + 1'b1;
                state_next = (ptr_reg == SI_W'(SETS - 1)) ? ST_IDLE : ST_DRD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ptr_reg   <= '0;
            sel_reg   <= SEL_RESET;
            fc_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            sel_reg   <= sel_next;
            fc_reg    <= fc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ovw_reg <= ovw_next;
        ovs_reg <= ovs_next;
    end

endmodule

FILE: design/dead_block_srrip_dip_replacement_core.sv
// Result path: an item waits in the front-end queue, its row is read in ST_IDLE, then ST_EXEC modifies it,
// writes it back and registers the result. Items go one at a time; none is taken while an unpopped result waits.
// A fill that completes a decay period adds a read and write-back sweep over all SETS rows (2048 by default).
// Reset: asynchronous, active low; a clearing sweep over all SETS rows (2048) follows,
// during which items queue up to two deep and then full holds.
// ---------------------------------------------------------------------------
// dead_block_srrip_dip_replacement_core
// Top level: front end classifies items, back end updates the metadata.
// ---------------------------------------------------------------------------
module dead_block_srrip_dip_replacement_core
    import dbsd_pkg::*;
#(
    parameter int SETS         = DEF_SETS,
    parameter int WAYS         = DEF_WAYS,
    parameter int LEADER_SETS  = DEF_LEADER_SETS,
    parameter int DECAY_PERIOD = DEF_DECAY_PERIOD
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              cmd,
    input  logic [SET_W-1:0]  set_index,
    input  logic [WAY_W-1:0]  way,
    input  logic              hit,
    input  logic [MASK_W-1:0] valid_mask,
    input  logic [DRAW_W-1:0] bip_draw,
    output logic              empty,
    input  logic              pop,
    output logic [WAY_W-1:0]  victim_way,
    output logic [SEL_W-1:0]  selector_value
);

    logic       q_valid, q_take;
    dbsd_item_t q_item;

    dbsd_front #(.SETS(SETS), .WAYS(WAYS), .LEADER_SETS(LEADER_SETS)) u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .set_index(set_index), .way(way), .hit(hit), .valid_mask(valid_mask),
        .bip_draw(bip_draw), .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
    );

    dbsd_back #(.SETS(SETS), .WAYS(WAYS), .DECAY_PERIOD(DECAY_PERIOD)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_take(q_take), .empty(empty), .pop(pop), .victim_way(victim_way),
        .selector_value(selector_value)
    );

endmodule

FILE: design/dbsd_checker.sv
// ---------------------------------------------------------------------------
// dbsd_checker
// Port-level checks on the replacement core, bound to the top level.
// ---------------------------------------------------------------------------
module dbsd_checker
    import dbsd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             full,
    input logic             push,
    input logic             cmd,
    input logic             empty,
    input logic             pop,
    input logic [WAY_W-1:0] victim_way,
    input logic [SEL_W-1:0] selector_value
);

    // result waiting and not taken holds still
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(victim_way) && $stable(selector_value))
        else $error("result changed while waiting");

    // a waiting result carries known values
    a_known_out: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown({victim_way, selector_value}))
        else $error("unknown result fields");

    // an input transfer carries a known command
    a_known_in: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |-> !$isunknown(cmd))
        else $error("unknown command on input transfer");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result after reset");

    // no result appears in the cycle after a waiting result was taken
    a_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop |=> empty)
        else $error("result repeated");

endmodule

bind dead_block_srrip_dip_replacement_core dbsd_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .full(full), .push(push), .cmd(cmd), .empty(empty),
    .pop(pop), .victim_way(victim_way), .selector_value(selector_value)
);

FILE: tb/dead_block_srrip_dip_replacement_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dead_block_srrip_dip_replacement_core_test
// Drives victim searches, hits and fills through the queue-style ports and
// checks every result against a cycle-free model of the replacement state
// (RRPV, reuse counters, duel selector and periodic reuse decay).
// ---------------------------------------------------------------------------
module dead_block_srrip_dip_replacement_core_test;
    import dbsd_pkg::*;

    localparam int NBLK    = DEF_SETS * DEF_WAYS;
    localparam int LIMIT   = 3000000;
    // short decay period so a sweep is reached with a modest number of fills
    localparam int T_DECAY = 256;

    typedef struct {
        logic              cmd;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way;
        logic              hit;
        logic [MASK_W-1:0] valid_mask;
        logic [DRAW_W-1:0] bip_draw;
    } access_t;

    // Replacement state model plus the queue of results still to arrive
    class repl_scoreboard;
        logic [3:0]       meta [NBLK];
        logic [SEL_W-1:0] sel;
        int unsigned      fills;
        int unsigned      decays;
        logic [WAY_W-1:0] want_victim [$];
        logic [SEL_W-1:0] want_sel [$];
        logic [WAY_W-1:0] last_victim;
        int               errors;
        int               checked;

        function new();
            foreach (meta[i])
                meta[i] = 4'd0;
            sel = SEL_RESET;
            fills = 0;
            decays = 0;
            errors = 0;
            checked = 0;
            last_victim = '0;
        endfunction

        function logic [WAY_W-1:0] pick_victim(int base, logic [MASK_W-1:0] mask);
            logic [1:0] maxr;
            for (int w = 0; w < DEF_WAYS; w++)
                if (!mask[w])
                    return WAY_W'(w);
            maxr = 2'd0;
            for (int w = 0; w < DEF_WAYS; w++)
                if (meta[base+w][1:0] > maxr)
                    maxr = meta[base+w][1:0];
            if (maxr != RRPV_DISTANT)
                for (int w = 0; w < DEF_WAYS; w++)
                    meta[base+w][1:0] = meta[base+w][1:0] + (RRPV_DISTANT - maxr);
            for (int w = 0; w < DEF_WAYS; w++)
                if (meta[base+w][1:0] == RRPV_DISTANT)
                    return WAY_W'(w);
            return '0;
        endfunction

        function void note_input(access_t a);
            int         set;
            int         idx;
            logic       ls;
            logic       lb;
            logic [1:0] bip;
            logic [1:0] ins;
            logic [1:0] r;
            logic [WAY_W-1:0] v;
            set = a.set_index % DEF_SETS;
            idx = set * DEF_WAYS + a.way;
            ls = set < DEF_LEADER_SETS;
            lb = set >= DEF_SETS / 2 && set < DEF_SETS / 2 + DEF_LEADER_SETS;
            bip = (a.bip_draw == 0) ? RRPV_LONG : RRPV_DISTANT;
            v = '0;
            if (a.cmd == CMD_VICTIM) begin
                v = pick_victim(set * DEF_WAYS, a.valid_mask);
                last_victim = v;
            end
            else if (a.hit) begin
                r = meta[idx][3:2];
                meta[idx] = {(r == 2'd3) ? r : r + 2'd1, 2'd0};
                if (ls && sel != SEL_MAX)
                    sel = sel + 1'b1;
                if (lb && sel != 0)
                    sel = sel - 1'b1;
            end
            else begin
                fills++;
                if (meta[idx][3:2] == 2'd0)
                    ins = RRPV_DISTANT;
                else if (ls)
                    ins = RRPV_LONG;
                else if (lb)
                    ins = bip;
                else
                    ins = (sel >= SEL_RESET) ? RRPV_LONG : bip;
                meta[idx] = {2'd0, ins};
                if (fills >= T_DECAY) begin
                    fills = 0;
                    decays++;
                    foreach (meta[i])
                        if (meta[i][3:2] != 0)
                            meta[i][3:2] = meta[i][3:2] - 2'd1;
                end
            end
            want_victim.insert(want_victim.size(), v);
            want_sel.insert(want_sel.size(), sel);
        endfunction

        function void check_result(logic [WAY_W-1:0] v, logic [SEL_W-1:0] s);
            logic [WAY_W-1:0] ev;
            logic [SEL_W-1:0] es;
            if (want_victim.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            ev = want_victim.pop_front();
            es = want_sel.pop_front();
            checked++;
            if (v !== ev) begin
                $error("victim_way: expected %0d, got %0d", ev, v);
                errors++;
            end
            if (s !== es) begin
                $error("selector_value: expected %0d, got %0d", es, s);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              cmd;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way;
    logic              hit;
    logic [MASK_W-1:0] valid_mask;
    logic [DRAW_W-1:0] bip_draw;
    logic              empty;
    logic              pop;
    logic [WAY_W-1:0]  victim_way;
    logic [SEL_W-1:0]  selector_value;

    repl_scoreboard sb;
    bit             quiet;
    int unsigned    cycles;
    int unsigned    sent;
    int             hot [8];

    dead_block_srrip_dip_replacement_core #(.DECAY_PERIOD(T_DECAY)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .set_index      (set_index),
        .way            (way),
        .hit            (hit),
        .valid_mask     (valid_mask),
        .bip_draw       (bip_draw),
        .empty          (empty),
        .pop            (pop),
        .victim_way     (victim_way),
        .selector_value (selector_value)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    // Result side: pop with random stalls, check each transfer
    initial
    begin
        int stall;
        stall = 0;
        pop = 1'b0;
        forever begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(victim_way, selector_value);
            if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end
            else begin
                pop <= 1'b1;
                stall = gap_len();
            end
        end
    end

    task automatic send(access_t a);
        int g;
        cmd        <= a.cmd;
        set_index  <= a.set_index;
        way        <= a.way;
        hit        <= a.hit;
        valid_mask <= a.valid_mask;
        bip_draw   <= a.bip_draw;
        push       <= 1'b1;
        do
            @(posedge clk);
        while (full);
        sb.note_input(a);
        sent++;
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_op(logic c, int s, int w, logic h, logic [MASK_W-1:0] m, int d);
        access_t a;
        a.cmd = c;
        a.set_index = SET_W'(s);
        a.way = WAY_W'(w);
        a.hit = h;
        a.valid_mask = m;
        a.bip_draw = DRAW_W'(d);
        send(a);
    endtask

    function int pick_set();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return hot[$urandom_range(0, 7)];
        if (r < 7)
            return $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(1024, 1087);
        return $urandom_range(0, 2047);
    endfunction

    function int pick_draw();
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, 31);
    endfunction

    // One mixed step: mostly a miss (victim search then fill of that victim),
    // otherwise hits and odd standalone commands
    task automatic mixed_step();
        int s;
        int r;
        logic [MASK_W-1:0] m;
        s = pick_set();
        r = $urandom_range(0, 99);
        if (r < 55) begin
            m = ($urandom_range(0, 3) != 0) ? 16'hFFFF : 16'(~(1 << $urandom_range(0, 15)));
            send_op(CMD_VICTIM, s, $urandom_range(0, 15), $urandom_range(0, 1), m,
                    $urandom_range(0, 31));
            send_op(CMD_UPDATE, s, sb.last_victim, 1'b0, 16'($urandom), pick_draw());
        end
        else if (r < 85)
            send_op(CMD_UPDATE, s, $urandom_range(0, 15), 1'b1, 16'($urandom), pick_draw());
        else if (r < 93)
            send_op(CMD_VICTIM, s, $urandom_range(0, 15), $urandom_range(0, 1),
                    16'($urandom), $urandom_range(0, 31));
        else
            send_op(CMD_UPDATE, s, $urandom_range(0, 15), 1'b0, 16'($urandom), pick_draw());
        if ($urandom_range(0, 199) == 0)
            quiet = !quiet;
    endtask

    initial
    begin
        int wait_cycles;
        sb = new();
        cycles = 0;
        sent = 0;
        quiet = 1'b0;
        push = 1'b0;
        cmd = CMD_VICTIM;
        set_index = '0;
        way = '0;
        hit = 1'b0;
        valid_mask = '0;
        bip_draw = '0;
        rst_n = 1'b0;
        foreach (hot[i])
            hot[i] = $urandom_range(0, 2047);
        hot[0] = 0;
        hot[1] = 1087;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: mask extremes, aging, leader hits, dead and live fills
        send_op(CMD_VICTIM, 5, 0, 0, 16'h0000, 0);
        send_op(CMD_VICTIM, 5, 0, 0, 16'h7FFF, 0);
        send_op(CMD_VICTIM, 5, 0, 0, 16'hFFFF, 0);
        send_op(CMD_VICTIM, 5, 0, 0, 16'hFFFF, 31);
        send_op(CMD_UPDATE, 0, 15, 1, 16'hFFFF, 0);
        send_op(CMD_UPDATE, 0, 15, 0, 16'h0000, 0);
        send_op(CMD_UPDATE, 0, 15, 0, 16'h0000, 0);
        send_op(CMD_UPDATE, 1024, 0, 1, 16'h0000, 31);
        send_op(CMD_UPDATE, 1024, 0, 0, 16'h0000, 0);
        send_op(CMD_UPDATE, 1024, 0, 1, 16'h0000, 0);
        send_op(CMD_UPDATE, 1024, 0, 0, 16'h0000, 31);
        send_op(CMD_UPDATE, 2047, 7, 1, 16'h0000, 0);
        send_op(CMD_UPDATE, 2047, 7, 1, 16'h0000, 0);
        send_op(CMD_UPDATE, 2047, 7, 1, 16'h0000, 0);
        send_op(CMD_UPDATE, 2047, 7, 1, 16'h0000, 0);
        send_op(CMD_UPDATE, 2047, 7, 0, 16'hFFFF, 31);
        send_op(CMD_VICTIM, 2047, 0, 1, 16'hFFFF, 0);
        send_op(CMD_VICTIM, 1087, 0, 1, 16'hFFFE, 0);
        send_op(CMD_UPDATE, 63, 3, 1, 16'hFFFF, 0);

        repeat (150)
            mixed_step();
        // Drive the selector down to its floor with BIP leader hits
        repeat (560)
            send_op(CMD_UPDATE, $urandom_range(1024, 1087), $urandom_range(0, 15), 1'b1,
                    16'($urandom), pick_draw());
        repeat (100)
            mixed_step();

        // Enough fills to cross a decay period, then look at the decayed state
        quiet = 1'b1;
        while (sb.decays == 0)
            send_op(CMD_UPDATE, pick_set(), $urandom_range(0, 15), 1'b0,
                    16'($urandom), pick_draw());
        quiet = 1'b0;
        repeat (50)
            mixed_step();

        push <= 1'b0;
        wait_cycles = 0;
        while (sb.want_victim.size() != 0 && wait_cycles < 200000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (sb.want_victim.size() != 0) begin
            $error("%0d expected results never arrived", sb.want_victim.size());
            sb.errors++;
        end
        $display("Sent %0d accesses, checked %0d results, %0d reuse decay(s), selector %0d",
                 sent, sb.checked, sb.decays, sb.sel);
        $display("Covered victim search and aging, leader hits down to the selector floor,");
        $display("dead and live fills under both duel outcomes and a reuse decay sweep");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
design/dbsd_pkg.sv
design/dbsd_front.sv
design/dbsd_back.sv
design/dead_block_srrip_dip_replacement_core.sv
design/dbsd_checker.sv
tb/dead_block_srrip_dip_replacement_core_test.sv
